/* rtl/sprite_bounded_motion_assert.svh */
// assertion macros for the sprite motion block
// used by the top level only; expands to nothing when SYNTHESIS is defined
`ifndef SPRITE_BOUNDED_MOTION_ASSERT_SVH
`define SPRITE_BOUNDED_MOTION_ASSERT_SVH
`ifndef SYNTHESIS
`define SBM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbm assertion failed");
`define SBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbm assertion failed");
`else
`define SBM_ASSERT_NOW(label, ante, cons)
`define SBM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/sbm_pkg.sv */
// shared types and constants for the sprite motion block
// no dependencies; imported by every module of the block
`default_nettype none
package sbm_pkg;

  localparam int FIELD_BITS = 16;
  localparam int FRAME_BITS = 8;
  localparam int PROD_BITS  = 32;
  localparam int REM_BITS   = 16;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_LEFT   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TOP    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOTTOM = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE   = 3'd4;

  localparam logic signed [FIELD_BITS-1:0] BOUND_HI_RESET = 16'sd50;
  localparam logic signed [FIELD_BITS-1:0] VEL_MAX = 16'sh7FFF;
  localparam logic signed [FIELD_BITS-1:0] VEL_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    EDGE_IGNORE,
    EDGE_STOP,
    EDGE_WRAP,
    EDGE_BOUNCE
  } edge_mode_t;

  typedef enum logic [1:0] {
    OP_SET_VEL,
    OP_MOVE,
    OP_FWD_BOUNDED,
    OP_FWD_FREE
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_PREP,
    ST_DIV,
    ST_APPLY,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic prep;
    logic div_step;
    logic apply;
    logic commit;
  } sbm_cmd_t;

  typedef struct packed {
    logic need_div;
  } sbm_sts_t;

endpackage
`default_nettype wire

/* rtl/sbm_rem.sv */
// remainder unit: restoring division, two dividend bits per step
// uses sbm_pkg; stepped by the datapath under controller command
`default_nettype none
module sbm_rem #(
  parameter int DIV_W = 34
) (
  input  wire logic                         clk,
  input  wire logic                         load,
  input  wire logic                         step,
  input  wire logic [DIV_W-1:0]             dividend,
  input  wire logic [sbm_pkg::REM_BITS-1:0] divisor,
  output logic      [sbm_pkg::REM_BITS-1:0] rem
);
  import sbm_pkg::*;

  logic [DIV_W-1:0]    quo_r;
  logic [REM_BITS-1:0] rem_r;
  logic [REM_BITS-1:0] dvs_r;
  logic [REM_BITS:0]   r1;
  logic [REM_BITS:0]   r2;
  logic [REM_BITS-1:0] rem_nxt;

  always_comb begin
    r1 = {rem_r, quo_r[DIV_W-1]};
    if (r1 >= {1'b0, dvs_r}) begin
      r1 = r1 - {1'b0, dvs_r};
    end
    r2 = {r1[REM_BITS-1:0], quo_r[DIV_W-2]};
    if (r2 >= {1'b0, dvs_r}) begin
      r2 = r2 - {1'b0, dvs_r};
    end
    rem_nxt = r2[REM_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (step) begin
      quo_r <= {quo_r[DIV_W-3:0], 2'b00};
      rem_r <= rem_nxt;
    end
  end

  assign rem = rem_r;

endmodule
`default_nettype wire

/* rtl/sbm_ctrl.sv */
// controller: sequences one item through multiply, edge check, remainder and commit
// uses sbm_pkg; drives commands to sbm_datapath and owns the result valid
`default_nettype none
module sbm_ctrl #(
  parameter int COORD_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire sbm_pkg::sbm_sts_t sts,
  output sbm_pkg::sbm_cmd_t      cmd
);
  import sbm_pkg::*;

  localparam int SUM_W     = ((COORD_BITS > PROD_BITS) ? COORD_BITS : PROD_BITS) + 2;
  localparam int DIV_STEPS = (SUM_W + 1) / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_PREP;
      ST_PREP: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        if (!sts.need_div || cnt_r == CNT_LAST) begin
          state_nxt = ST_APPLY;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_APPLY: state_nxt = ST_COMMIT;
      ST_COMMIT: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_tready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_MUL:    cmd.mul      = 1'b1;
      ST_SUM:    cmd.sum      = 1'b1;
      ST_PREP:   cmd.prep     = 1'b1;
      ST_DIV:    cmd.div_step = sts.need_div;
      ST_APPLY:  cmd.apply    = 1'b1;
      ST_COMMIT: cmd.commit   = out_free;
      default:   cmd          = '0;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

/* rtl/sbm_datapath.sv */
// datapath: sprite state, bound registers, multipliers, edge rule and result register
// uses sbm_pkg and sbm_rem; steered by sbm_ctrl commands
`default_nettype none
module sbm_datapath #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire sbm_pkg::sbm_cmd_t                   cmd,
  output sbm_pkg::sbm_sts_t                        sts,
  input  wire logic [1:0]                          in_operation,
  input  wire logic signed [sbm_pkg::FIELD_BITS-1:0] in_target_x,
  input  wire logic signed [sbm_pkg::FIELD_BITS-1:0] in_target_y,
  input  wire logic signed [sbm_pkg::FIELD_BITS-1:0] in_step_multiplier,
  input  wire logic [sbm_pkg::FRAME_BITS-1:0]      in_new_frame,
  input  wire logic                                cfg_we,
  input  wire logic [sbm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [sbm_pkg::FIELD_BITS-1:0]      cfg_data,
  output logic signed [sbm_pkg::FIELD_BITS-1:0]    out_pos_x,
  output logic signed [sbm_pkg::FIELD_BITS-1:0]    out_pos_y,
  output logic signed [sbm_pkg::FIELD_BITS-1:0]    out_vel_x,
  output logic signed [sbm_pkg::FIELD_BITS-1:0]    out_vel_y,
  output logic [sbm_pkg::FRAME_BITS-1:0]           out_cur_frame,
  output logic                                     out_outside_area,
  output logic                                     out_position_changed
);
  import sbm_pkg::*;

  localparam int SUM_W     = ((COORD_BITS > PROD_BITS) ? COORD_BITS : PROD_BITS) + 2;
  localparam int DIV_STEPS = (SUM_W + 1) / 2;
  localparam int DIV_W     = 2 * DIV_STEPS;
  localparam logic signed [SUM_W-1:0] CMAX = (SUM_W'(1) <<< (COORD_BITS - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] CMIN = ~CMAX;

  // axis 0 is x, axis 1 is y
  logic signed [FIELD_BITS-1:0] lo_r [2];
  logic signed [FIELD_BITS-1:0] hi_r [2];
  edge_mode_t                   mode_r;

  logic signed [COORD_BITS-1:0] cur_r [2];
  logic signed [FIELD_BITS-1:0] vel_r [2];
  logic [FRAME_BITS-1:0]        frame_r;

  op_t                          op_r;
  logic signed [FIELD_BITS-1:0] tgt_r [2];
  logic signed [FIELD_BITS-1:0] mul_r;
  logic [FRAME_BITS-1:0]        nf_r;

  logic signed [PROD_BITS-1:0]  prod_r [2];
  logic signed [SUM_W-1:0]      sum_r [2];
  logic                         below_r [2];
  logic                         above_r [2];
  logic                         zero_r [2];
  logic signed [COORD_BITS-1:0] npos_r [2];
  logic signed [FIELD_BITS-1:0] nvel_r [2];

  logic signed [SUM_W-1:0]      cur_ext [2];
  logic signed [SUM_W-1:0]      prod_ext [2];
  logic signed [SUM_W-1:0]      tgt_ext [2];
  logic signed [SUM_W-1:0]      lo_ext [2];
  logic signed [SUM_W-1:0]      hi_ext [2];
  logic signed [SUM_W-1:0]      sum_nxt [2];
  logic                         below_c [2];
  logic                         above_c [2];
  logic [SUM_W-1:0]             ovr_c [2];
  logic [DIV_W-1:0]             dividend_c [2];
  logic signed [FIELD_BITS:0]   span_c [2];
  logic [FIELD_BITS:0]          span_abs_c [2];
  logic [REM_BITS-1:0]          divisor_c [2];
  logic [REM_BITS-1:0]          rem_c [2];
  logic signed [SUM_W-1:0]      rv_ext [2];
  logic signed [SUM_W-1:0]      edge_c [2];
  logic signed [SUM_W-1:0]      sat_c [2];
  logic                         bounce_c [2];
  logic signed [COORD_BITS-1:0] npos_c [2];
  logic signed [FIELD_BITS-1:0] nvel_c [2];
  logic signed [SUM_W-1:0]      npos_ext [2];
  logic                         outside_c;
  logic                         changed_c;
  logic [FRAME_BITS-1:0]        frame_nxt;
  logic                         bounded_op;
  logic                         folding_mode;

  assign bounded_op   = (op_r == OP_MOVE) || (op_r == OP_FWD_BOUNDED);
  assign folding_mode = (mode_r == EDGE_WRAP) || (mode_r == EDGE_BOUNCE);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      cur_ext[i]  = {{(SUM_W-COORD_BITS){cur_r[i][COORD_BITS-1]}}, cur_r[i]};
      prod_ext[i] = {{(SUM_W-PROD_BITS){prod_r[i][PROD_BITS-1]}}, prod_r[i]};
      tgt_ext[i]  = {{(SUM_W-FIELD_BITS){tgt_r[i][FIELD_BITS-1]}}, tgt_r[i]};
      lo_ext[i]   = {{(SUM_W-FIELD_BITS){lo_r[i][FIELD_BITS-1]}}, lo_r[i]};
      hi_ext[i]   = {{(SUM_W-FIELD_BITS){hi_r[i][FIELD_BITS-1]}}, hi_r[i]};
      sum_nxt[i]  = (op_r == OP_MOVE) ? tgt_ext[i] : cur_ext[i] + prod_ext[i];

      below_c[i]  = sum_r[i] < lo_ext[i];
      above_c[i]  = !below_c[i] && (sum_r[i] > hi_ext[i]);
      ovr_c[i]    = below_c[i] ? lo_ext[i] - sum_r[i] : sum_r[i] - hi_ext[i];
      dividend_c[i] = DIV_W'(ovr_c[i]);
      span_c[i]   = {hi_r[i][FIELD_BITS-1], hi_r[i]} - {lo_r[i][FIELD_BITS-1], lo_r[i]};
      span_abs_c[i] = span_c[i][FIELD_BITS] ? -span_c[i] : span_c[i];
      divisor_c[i]  = span_abs_c[i][REM_BITS-1:0];

      rv_ext[i] = zero_r[i] ? '0 : {{(SUM_W-REM_BITS){1'b0}}, rem_c[i]};
      edge_c[i] = sum_r[i];
      if (bounded_op && below_r[i]) begin
        case (mode_r)
          EDGE_STOP:   edge_c[i] = lo_ext[i];
          EDGE_WRAP:   edge_c[i] = hi_ext[i] - rv_ext[i];
          EDGE_BOUNCE: edge_c[i] = lo_ext[i] + rv_ext[i];
          default:     edge_c[i] = sum_r[i];
        endcase
      end else if (bounded_op && above_r[i]) begin
        case (mode_r)
          EDGE_STOP:   edge_c[i] = hi_ext[i];
          EDGE_WRAP:   edge_c[i] = lo_ext[i] + rv_ext[i];
          EDGE_BOUNCE: edge_c[i] = hi_ext[i] - rv_ext[i];
          default:     edge_c[i] = sum_r[i];
        endcase
      end
      if (edge_c[i] > CMAX) begin
        sat_c[i] = CMAX;
      end else if (edge_c[i] < CMIN) begin
        sat_c[i] = CMIN;
      end else begin
        sat_c[i] = edge_c[i];
      end
      bounce_c[i] = bounded_op && (below_r[i] || above_r[i]) && (mode_r == EDGE_BOUNCE);

      if (op_r == OP_SET_VEL) begin
        npos_c[i] = cur_r[i];
        nvel_c[i] = tgt_r[i];
      end else begin
        npos_c[i] = sat_c[i][COORD_BITS-1:0];
        if (bounce_c[i]) begin
          nvel_c[i] = (vel_r[i] == VEL_MIN) ? VEL_MAX : -vel_r[i];
        end else begin
          nvel_c[i] = vel_r[i];
        end
      end
      npos_ext[i] = {{(SUM_W-COORD_BITS){npos_r[i][COORD_BITS-1]}}, npos_r[i]};
    end
  end

  always_comb begin
    frame_nxt = bounded_op ? nf_r : frame_r;
    outside_c = (npos_ext[0] < lo_ext[0]) || (npos_ext[0] > hi_ext[0]) ||
                (npos_ext[1] < lo_ext[1]) || (npos_ext[1] > hi_ext[1]);
    changed_c = (npos_r[0] != cur_r[0]) || (npos_r[1] != cur_r[1]) ||
                (frame_nxt != frame_r);
    sts.need_div = bounded_op && folding_mode &&
                   (((below_r[0] || above_r[0]) && !zero_r[0]) ||
                    ((below_r[1] || above_r[1]) && !zero_r[1]));
  end

  for (genvar g = 0; g < 2; g++) begin : g_rem
    sbm_rem #(
      .DIV_W(DIV_W)
    ) u_rem (
      .clk      (clk),
      .load     (cmd.prep),
      .step     (cmd.div_step),
      .dividend (dividend_c[g]),
      .divisor  (divisor_c[g]),
      .rem      (rem_c[g])
    );
  end

  // bound registers and sprite state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r[0]  <= '0;
      lo_r[1]  <= '0;
      hi_r[0]  <= BOUND_HI_RESET;
      hi_r[1]  <= BOUND_HI_RESET;
      mode_r   <= EDGE_IGNORE;
      cur_r[0] <= '0;
      cur_r[1] <= '0;
      vel_r[0] <= '0;
      vel_r[1] <= '0;
      frame_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LEFT:   lo_r[0] <= cfg_data;
          REG_TOP:    lo_r[1] <= cfg_data;
          REG_RIGHT:  hi_r[0] <= cfg_data;
          REG_BOTTOM: hi_r[1] <= cfg_data;
          REG_MODE:   mode_r  <= edge_mode_t'(cfg_data[1:0]);
          default: ;
        endcase
      end
      if (cmd.commit) begin
        cur_r[0] <= npos_r[0];
        cur_r[1] <= npos_r[1];
        vel_r[0] <= nvel_r[0];
        vel_r[1] <= nvel_r[1];
        frame_r  <= frame_nxt;
      end
    end
  end

  // item payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= op_t'(in_operation);
      tgt_r[0] <= in_target_x;
      tgt_r[1] <= in_target_y;
      mul_r    <= in_step_multiplier;
      nf_r     <= in_new_frame;
    end
    for (int i = 0; i < 2; i++) begin
      if (cmd.mul) begin
        prod_r[i] <= mul_r * vel_r[i];
      end
      if (cmd.sum) begin
        sum_r[i] <= sum_nxt[i];
      end
      if (cmd.prep) begin
        below_r[i] <= below_c[i];
        above_r[i] <= above_c[i];
        zero_r[i]  <= (span_c[i] == '0);
      end
      if (cmd.apply) begin
        npos_r[i] <= npos_c[i];
        nvel_r[i] <= nvel_c[i];
      end
    end
    if (cmd.commit) begin
      out_pos_x            <= npos_ext[0][FIELD_BITS-1:0];
      out_pos_y            <= npos_ext[1][FIELD_BITS-1:0];
      out_vel_x            <= nvel_r[0];
      out_vel_y            <= nvel_r[1];
      out_cur_frame        <= frame_nxt;
      out_outside_area     <= outside_c;
      out_position_changed <= changed_c;
    end
  end

endmodule
`default_nettype wire

/* rtl/sprite_bounded_motion.sv */
// top level of the sprite motion block: ports, field packing and assertions
// uses sbm_pkg, sbm_ctrl, sbm_datapath and sprite_bounded_motion_assert.svh
//
// channel   dir  handshake            payload
// in        in   in_tvalid/in_tready  tuser: operation; tdata: target_x .. new_frame
// out       out  out_tvalid/out_tready tdata: pos_x .. position_changed
// cfg       in   cfg_we               cfg_index, cfg_data
//
// an item whose wrap or bounce folds an overshoot also passes through the
// radix-4 remainder units, two dividend bits per cycle over 34 bits
// the next item can be accepted in the cycle after the result is registered
// a waiting result stalls only the commit of the following item
// reset is synchronous, active low, and resets state and bound registers
`default_nettype none
module sprite_bounded_motion #(
  parameter int COORD_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // operation
  input  wire logic [55:0] in_tdata,   // target_x, target_y, step_multiplier, new_frame
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // pos_x, pos_y, vel_x, vel_y, cur_frame, outside_area, position_changed, zero pad
  output logic [79:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import sbm_pkg::*;
  `include "sprite_bounded_motion_assert.svh"

  sbm_cmd_t cmd;
  sbm_sts_t sts;

  logic signed [FIELD_BITS-1:0] pos_x;
  logic signed [FIELD_BITS-1:0] pos_y;
  logic signed [FIELD_BITS-1:0] vel_x;
  logic signed [FIELD_BITS-1:0] vel_y;
  logic [FRAME_BITS-1:0]        cur_frame;
  logic                         outside_area;
  logic                         position_changed;

  sbm_ctrl #(
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sbm_datapath #(
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_operation         (in_tuser),
    .in_target_x          (in_tdata[15:0]),
    .in_target_y          (in_tdata[31:16]),
    .in_step_multiplier   (in_tdata[47:32]),
    .in_new_frame         (in_tdata[55:48]),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_pos_x            (pos_x),
    .out_pos_y            (pos_y),
    .out_vel_x            (vel_x),
    .out_vel_y            (vel_y),
    .out_cur_frame        (cur_frame),
    .out_outside_area     (outside_area),
    .out_position_changed (position_changed)
  );

  assign out_tdata = {6'b0, position_changed, outside_area, cur_frame,
                      vel_y, vel_x, pos_y, pos_x};

  `SBM_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `SBM_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_tvalid)
  `SBM_ASSERT_NEXT(a_taken_result_clears, out_tvalid && out_tready && !cmd.commit, !out_tvalid)
  `SBM_ASSERT_NOW(a_no_commit_over_result, cmd.commit, !out_tvalid || out_tready)

endmodule
`default_nettype wire
